FILE: hdl/fcti_pkg.sv
// Shared types, constants and helpers of the floor/ceiling texture-coordinate interpolator.
`default_nettype none

package fcti_pkg;

    // texture size, a power of two is cheapest but any size up to 64 works (6-bit texel)
    localparam int TEX_W = 64;
    localparam int TEX_H = 64;

    localparam int FRAC_BITS = 24;            // accumulator is Q23.24
    localparam int ACC_W     = 48;
    localparam int DIST_W    = 32;
    localparam int DIR_W     = 17;            // dir +/- plane, Q3.14
    localparam int PROD_W    = DIST_W + 1 + DIR_W;
    localparam int FLR_W     = PROD_W - 6;    // floor(prod / 64)
    localparam int DIFF_W    = FLR_W + 1;
    localparam int MAG_W     = FLR_W;         // |right - left| fits here
    localparam int DIV_CW    = $clog2(MAG_W);
    localparam int MUL_CW    = 3;
    localparam int TEXP_W    = FRAC_BITS + 13;
    localparam int TEXEL_W   = 6;
    localparam int COORD_W   = 12;

    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = Q_AW + 1;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // register map, word index
    localparam logic [REG_IDX_W-1:0] REG_PLAYER_X       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PLAYER_Y       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_DIR_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_DIR_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_PLANE_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_PLANE_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd7;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [DIST_W-1:0]  row_distance;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] floor_row;
        logic [COORD_W-1:0] ceiling_row;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] player_x;
        logic signed [31:0] player_y;
        logic signed [15:0] view_dir_x;
        logic signed [15:0] view_dir_y;
        logic signed [15:0] camera_plane_x;
        logic signed [15:0] camera_plane_y;
        logic [COORD_W-1:0] screen_width;
        logic [COORD_W-1:0] screen_height;
    } t_cfg;

    typedef struct packed {
        logic     row_start;
        t_in_item item;
    } t_q_item;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] acc_x;
        logic [ACC_W-1:0] acc_y;
        logic [ACC_W-1:0] step_x;
        logic [ACC_W-1:0] step_y;
    } t_setup_res;

    typedef enum logic [1:0] {
        SU_IDLE,
        SU_MUL,
        SU_DIV,
        SU_FIN
    } t_setup_state;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_SETUP,
        BK_EMIT
    } t_back_state;

    // floor(frac(acc) * size), kept to the texel width
    function automatic logic [TEXEL_W-1:0] texel_of(input logic [ACC_W-1:0] acc,
                                                    input int unsigned size);
        logic [TEXP_W-1:0] prod;
        prod = {13'd0, acc[FRAC_BITS-1:0]} * TEXP_W'(size);
        return prod[FRAC_BITS +: TEXEL_W];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fcti_cfg.sv
// APB register file holding the player, view and screen settings.
`default_nettype none

module fcti_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fcti_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fcti_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fcti_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output fcti_pkg::t_cfg                     o_cfg
);
    import fcti_pkg::*;

    t_cfg                   r_cfg;
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg               <= '0;
            r_cfg.screen_width  <= SCREEN_WIDTH_RST;
            r_cfg.screen_height <= SCREEN_HEIGHT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PLAYER_X:       r_cfg.player_x       <= pwdata;
                REG_PLAYER_Y:       r_cfg.player_y       <= pwdata;
                REG_VIEW_DIR_X:     r_cfg.view_dir_x     <= pwdata[15:0];
                REG_VIEW_DIR_Y:     r_cfg.view_dir_y     <= pwdata[15:0];
                REG_CAMERA_PLANE_X: r_cfg.camera_plane_x <= pwdata[15:0];
                REG_CAMERA_PLANE_Y: r_cfg.camera_plane_y <= pwdata[15:0];
                REG_SCREEN_WIDTH:   r_cfg.screen_width   <= pwdata[COORD_W-1:0];
                REG_SCREEN_HEIGHT:  r_cfg.screen_height  <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PLAYER_X:       prdata = r_cfg.player_x;
            REG_PLAYER_Y:       prdata = r_cfg.player_y;
            REG_VIEW_DIR_X:     prdata = {16'd0, r_cfg.view_dir_x};
            REG_VIEW_DIR_Y:     prdata = {16'd0, r_cfg.view_dir_y};
            REG_CAMERA_PLANE_X: prdata = {16'd0, r_cfg.camera_plane_x};
            REG_CAMERA_PLANE_Y: prdata = {16'd0, r_cfg.camera_plane_y};
            REG_SCREEN_WIDTH:   prdata = {20'd0, r_cfg.screen_width};
            REG_SCREEN_HEIGHT:  prdata = {20'd0, r_cfg.screen_height};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/fcti_front.sv
// Front end: takes pixel requests, tags row starts and queues them for the back end.
`default_nettype none

module fcti_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire fcti_pkg::t_in_item  i_item,
    output logic                     o_q_valid,
    output fcti_pkg::t_q_item        o_q_item,
    input  wire logic                i_q_pop
);
    import fcti_pkg::*;

    t_q_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wptr;
    logic [Q_AW-1:0]    r_rptr;
    logic [Q_CW-1:0]    r_count;
    logic               w_wr;
    logic               w_rd;
    t_q_item            w_entry;

    assign o_full    = (r_count == Q_CW'(Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rptr];
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_q_pop && o_q_valid;

    always_comb begin
        w_entry.row_start = (i_item.column == '0);
        w_entry.item      = i_item;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fcti_setup.sv
// Row setup unit: edge positions through one shared multiplier, then a bit-serial step divide.
`default_nettype none

module fcti_setup (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [fcti_pkg::DIST_W-1:0] i_dist,
    input  wire fcti_pkg::t_cfg              i_cfg,
    output fcti_pkg::t_setup_res             o_res
);
    import fcti_pkg::*;

    t_setup_state               r_state;
    t_setup_state               n_state;
    logic [MUL_CW-1:0]          r_cnt;
    logic [DIV_CW-1:0]          r_dcnt;
    logic [DIST_W-1:0]          r_dist;
    logic signed [PROD_W-1:0]   r_prod;
    logic [FLR_W-1:0]           r_flx;
    logic [FLR_W-1:0]           r_fly;
    logic [ACC_W-1:0]           r_acc_x;
    logic [ACC_W-1:0]           r_acc_y;
    logic [DIFF_W-1:0]          r_diff_x;
    logic [DIFF_W-1:0]          r_diff_y;
    logic [MAG_W-1:0]           r_dq_x;
    logic [MAG_W-1:0]           r_dq_y;
    logic [COORD_W-1:0]         r_rem_x;
    logic [COORD_W-1:0]         r_rem_y;
    logic                       r_neg_x;
    logic                       r_neg_y;

    logic signed [DIR_W-1:0]    w_dmx, w_dpx, w_dmy, w_dpy, w_dir;
    logic signed [PROD_W-1:0]   w_prod;
    logic [FLR_W-1:0]           w_flr;
    logic [ACC_W-1:0]           w_flr48;
    logic [ACC_W-1:0]           w_pos_x, w_pos_y;
    logic [DIFF_W-1:0]          w_diff_ref, w_diff;
    logic [COORD_W-1:0]         w_div;
    logic [COORD_W:0]           w_sh_x, w_sh_y;
    logic                       w_ge_x, w_ge_y;
    logic [ACC_W-1:0]           w_q_x, w_q_y;
    logic                       w_mul_busy;

    // edge directions: dir - plane for the left edge, dir + plane for the right
    assign w_dmx = {i_cfg.view_dir_x[15], i_cfg.view_dir_x}
                 - {i_cfg.camera_plane_x[15], i_cfg.camera_plane_x};
    assign w_dpx = {i_cfg.view_dir_x[15], i_cfg.view_dir_x}
                 + {i_cfg.camera_plane_x[15], i_cfg.camera_plane_x};
    assign w_dmy = {i_cfg.view_dir_y[15], i_cfg.view_dir_y}
                 - {i_cfg.camera_plane_y[15], i_cfg.camera_plane_y};
    assign w_dpy = {i_cfg.view_dir_y[15], i_cfg.view_dir_y}
                 + {i_cfg.camera_plane_y[15], i_cfg.camera_plane_y};

    // product order: left x, left y, right x, right y
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_dir = w_dmx;
            2'd1:    w_dir = w_dmy;
            2'd2:    w_dir = w_dpx;
            default: w_dir = w_dpy;
        endcase
    end

    assign w_prod  = $signed({1'b0, r_dist}) * w_dir;
    assign w_flr   = r_prod[PROD_W-1:6];               // floor(prod / 64)
    assign w_flr48 = {{(ACC_W-FLR_W){w_flr[FLR_W-1]}}, w_flr};
    assign w_pos_x = {{8{i_cfg.player_x[31]}}, i_cfg.player_x, 8'h00};
    assign w_pos_y = {{8{i_cfg.player_y[31]}}, i_cfg.player_y, 8'h00};

    // player position cancels in right - left
    assign w_diff_ref = (r_cnt == 3'd3) ? {r_flx[FLR_W-1], r_flx} : {r_fly[FLR_W-1], r_fly};
    assign w_diff     = {w_flr[FLR_W-1], w_flr} - w_diff_ref;

    assign w_div  = (i_cfg.screen_width == '0) ? COORD_W'(1) : i_cfg.screen_width;
    assign w_sh_x = {r_rem_x, r_dq_x[MAG_W-1]};
    assign w_sh_y = {r_rem_y, r_dq_y[MAG_W-1]};
    assign w_ge_x = (w_sh_x >= {1'b0, w_div});
    assign w_ge_y = (w_sh_y >= {1'b0, w_div});

    assign w_q_x = {{(ACC_W-MAG_W){1'b0}}, r_dq_x};
    assign w_q_y = {{(ACC_W-MAG_W){1'b0}}, r_dq_y};

    assign w_mul_busy = (r_state == SU_MUL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SU_IDLE: if (i_start) n_state = SU_MUL;
            SU_MUL:  if (r_cnt == 3'd5) n_state = SU_DIV;
            SU_DIV:  if (r_dcnt == DIV_CW'(MAG_W - 1)) n_state = SU_FIN;
            SU_FIN:  n_state = SU_IDLE;
            default: n_state = SU_IDLE;
        endcase
    end

    always_comb begin
        o_res.done   = (r_state == SU_FIN);
        o_res.acc_x  = r_acc_x;
        o_res.acc_y  = r_acc_y;
        o_res.step_x = r_neg_x ? (ACC_W'(0) - w_q_x) : w_q_x;
        o_res.step_y = r_neg_y ? (ACC_W'(0) - w_q_y) : w_q_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_IDLE;
            r_cnt   <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (w_mul_busy) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == SU_DIV) begin
                r_dcnt <= r_dcnt + 1'b1;
            end else begin
                r_dcnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SU_IDLE && i_start) begin
            r_dist <= i_dist;
        end
        if (w_mul_busy) begin
            if (r_cnt < 3'd4) begin
                r_prod <= w_prod;
            end
            case (r_cnt)
                3'd1: begin
                    r_flx   <= w_flr;
                    r_acc_x <= w_pos_x + w_flr48;
                end
                3'd2: begin
                    r_fly   <= w_flr;
                    r_acc_y <= w_pos_y + w_flr48;
                end
                3'd3: r_diff_x <= w_diff;
                3'd4: r_diff_y <= w_diff;
                3'd5: begin
                    // load divider with magnitudes, quotient sign follows the difference
                    r_neg_x <= r_diff_x[DIFF_W-1];
                    r_neg_y <= r_diff_y[DIFF_W-1];
                    r_dq_x  <= r_diff_x[DIFF_W-1] ? MAG_W'(DIFF_W'(0) - r_diff_x)
                                                  : r_diff_x[MAG_W-1:0];
                    r_dq_y  <= r_diff_y[DIFF_W-1] ? MAG_W'(DIFF_W'(0) - r_diff_y)
                                                  : r_diff_y[MAG_W-1:0];
                    r_rem_x <= '0;
                    r_rem_y <= '0;
                end
                default: ;
            endcase
        end
        if (r_state == SU_DIV) begin
            r_rem_x <= w_ge_x ? COORD_W'(w_sh_x - {1'b0, w_div}) : w_sh_x[COORD_W-1:0];
            r_rem_y <= w_ge_y ? COORD_W'(w_sh_y - {1'b0, w_div}) : w_sh_y[COORD_W-1:0];
            r_dq_x  <= {r_dq_x[MAG_W-2:0], w_ge_x};
            r_dq_y  <= {r_dq_y[MAG_W-2:0], w_ge_y};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fcti_back.sv
// Back end: world-position accumulators, texel extraction and the result register.
`default_nettype none

module fcti_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire fcti_pkg::t_q_item            i_q_item,
    output logic                              o_q_pop,
    input  wire fcti_pkg::t_cfg               i_cfg,
    output logic                              o_start,
    output logic      [fcti_pkg::DIST_W-1:0]  o_dist,
    input  wire fcti_pkg::t_setup_res         i_res,
    output logic                              o_empty,
    input  wire logic                         i_pop,
    output fcti_pkg::t_out_item               o_out_item
);
    import fcti_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [ACC_W-1:0]   r_acc_x;
    logic [ACC_W-1:0]   r_acc_y;
    logic [ACC_W-1:0]   r_step_x;
    logic [ACC_W-1:0]   r_step_y;
    t_in_item           r_item;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_slot_free;
    logic               w_emit;
    logic               w_load;
    t_in_item           w_emit_item;
    t_out_item          w_res;

    assign w_slot_free = !r_out_valid || i_pop;
    assign o_empty     = !r_out_valid;
    assign o_out_item  = r_out;
    assign o_dist      = i_q_item.item.row_distance;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN:   if (i_q_valid && i_q_item.row_start) n_state = BK_SETUP;
            BK_SETUP: if (i_res.done) n_state = BK_EMIT;
            BK_EMIT:  if (w_slot_free) n_state = BK_RUN;
            default:  n_state = BK_RUN;
        endcase
    end

    always_comb begin
        o_start     = 1'b0;
        o_q_pop     = 1'b0;
        w_emit      = 1'b0;
        w_load      = 1'b0;
        w_emit_item = i_q_item.item;
        unique case (r_state)
            BK_RUN: begin
                o_start = i_q_valid && i_q_item.row_start;
                o_q_pop = i_q_valid && (i_q_item.row_start || w_slot_free);
                w_emit  = i_q_valid && !i_q_item.row_start && w_slot_free;
            end
            BK_SETUP: w_load = i_res.done;
            BK_EMIT: begin
                w_emit      = w_slot_free;
                w_emit_item = r_item;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_res.out_column  = w_emit_item.column;
        w_res.floor_row   = w_emit_item.row;
        w_res.ceiling_row = i_cfg.screen_height - w_emit_item.row - COORD_W'(1);
        w_res.texel_x     = texel_of(r_acc_x, TEX_W);
        w_res.texel_y     = texel_of(r_acc_y, TEX_H);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_out_valid <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_acc_x  <= i_res.acc_x;
                r_acc_y  <= i_res.acc_y;
                r_step_x <= i_res.step_x;
                r_step_y <= i_res.step_y;
            end else if (w_emit) begin
                r_acc_x <= r_acc_x + r_step_x;
                r_acc_y <= r_acc_y + r_step_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_start) begin
            r_item <= i_q_item.item;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/floor_ceiling_texcoord_interp_core.sv
// Floor/ceiling texture-coordinate interpolator: top level.
// A mid-row pixel passes the input queue, then the result register; a row start
// (column 0) launches setup through the shared edge multiplier, the bit-serial step
// divider and the hand-off, then is output. Throughput: one pixel per cycle within a
// row when neither side stalls; a row start holds the back end until setup is done.
// Reset (synchronous, active low) empties queue and result register, zeroes accumulators.
`default_nettype none

module floor_ceiling_texcoord_interp_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire fcti_pkg::t_in_item            i_in_item,
    output logic                               empty,
    input  wire logic                          pop,
    output fcti_pkg::t_out_item                o_out_item,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fcti_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fcti_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fcti_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import fcti_pkg::*;

    t_cfg               w_cfg;
    logic               w_q_valid;
    t_q_item            w_q_item;
    logic               w_q_pop;
    logic               w_start;
    logic [DIST_W-1:0]  w_dist;
    t_setup_res         w_res;

    fcti_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fcti_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_in_item),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    fcti_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_dist  (w_dist),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    fcti_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .i_cfg      (w_cfg),
        .o_start    (w_start),
        .o_dist     (w_dist),
        .i_res      (w_res),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

FILE: hdl/fcti_checker.sv
// Port-level checker for the interpolator core, bound to the top level.
`default_nettype none

module fcti_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire logic                 empty,
    input  wire logic                 pop,
    input  wire fcti_pkg::t_out_item  o_out_item
);
    import fcti_pkg::*;

    // requests taken but not yet delivered
    logic [Q_CW:0] r_pending;
    logic          w_in;
    logic          w_out;

    assign w_in  = push && !full;
    assign w_out = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({w_in, w_out})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> empty)
        else $error("result side not empty after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> empty)
        else $error("result offered with no request outstanding");

    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (r_pending >= (Q_CW + 1)'(Q_DEPTH)))
        else $error("full raised with fewer requests than queue depth");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed or vanished");

endmodule

bind floor_ceiling_texcoord_interp_core fcti_checker u_fcti_checker (.*);

`default_nettype wire

FILE: bench/floor_ceiling_texcoord_interp_core_tb.sv
// Testbench for the floor/ceiling texture-coordinate interpolator: directed and random pixels, self-checked.
`default_nettype none

module floor_ceiling_texcoord_interp_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcti_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic push = 1'b0;
    logic full;
    t_in_item i_in_item = '0;
    logic empty;
    logic pop = 1'b0;
    t_out_item o_out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    floor_ceiling_texcoord_interp_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the register file and the row walk state
    t_cfg        cfg_m;
    logic [47:0] floor_x_acc = '0;
    logic [47:0] floor_y_acc = '0;
    logic [47:0] col_step_x = '0;
    logic [47:0] col_step_y = '0;

    t_in_item  pixel_backlog[$];
    t_out_item texcoord_due[$];

    int  n_fail = 0;
    int  n_popped = 0;
    int  n_queued = 0;
    int  cycle_cnt = 0;
    int  push_idle_pct = 34;
    int  pop_idle_pct = 34;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  pixel_taken = 1'b0;

    // world position under one screen edge, Q.24, before wrapping
    function automatic longint edge_world(input logic signed [31:0] pos, input longint dir,
                                          input logic [31:0] rdist);
        longint prod;
        prod = longint'(rdist) * dir;
        return longint'(pos) * 256 + (prod >>> 6);
    endfunction

    function automatic t_out_item trace_floor_pixel(input t_in_item px);
        longint    lx, ly, rx, ry, span, q;
        longint    dx, dy, cx, cy;
        logic [63:0] tp;
        t_out_item r;
        if (px.column == '0) begin
            dx = longint'($signed(cfg_m.view_dir_x));
            dy = longint'($signed(cfg_m.view_dir_y));
            cx = longint'($signed(cfg_m.camera_plane_x));
            cy = longint'($signed(cfg_m.camera_plane_y));
            lx = edge_world(cfg_m.player_x, dx - cx, px.row_distance);
            ly = edge_world(cfg_m.player_y, dy - cy, px.row_distance);
            rx = edge_world(cfg_m.player_x, dx + cx, px.row_distance);
            ry = edge_world(cfg_m.player_y, dy + cy, px.row_distance);
            // a zero width divides as one
            span = (cfg_m.screen_width == '0) ? 64'sd1 : longint'(cfg_m.screen_width);
            floor_x_acc = lx[47:0];
            floor_y_acc = ly[47:0];
            q = (rx - lx) / span;
            col_step_x = q[47:0];
            q = (ry - ly) / span;
            col_step_y = q[47:0];
        end
        r.out_column  = px.column;
        r.floor_row   = px.row;
        r.ceiling_row = cfg_m.screen_height - px.row - 12'd1;
        tp = 64'(floor_x_acc[23:0]) * 64'(TEX_W);
        r.texel_x = tp[29:24];
        tp = 64'(floor_y_acc[23:0]) * 64'(TEX_H);
        r.texel_y = tp[29:24];
        floor_x_acc = floor_x_acc + col_step_x;
        floor_y_acc = floor_y_acc + col_step_y;
        return r;
    endfunction

    // requests taken at this edge go through the predictor
    always @(posedge i_clk) begin
        pixel_taken = push && !full;
        if (pixel_taken)
            texcoord_due.push_back(trace_floor_pixel(i_in_item));
    end

    always @(negedge i_clk) begin
        if (!push || pixel_taken) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= push_idle_pct) begin
                push <= 1'b1;
                i_in_item <= pixel_backlog.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (pop && !empty) begin
            n_popped++;
            if (texcoord_due.size() == 0) begin
                $error("unexpected result: column %0d row %0d",
                       o_out_item.out_column, o_out_item.floor_row);
                n_fail++;
            end else begin
                want = texcoord_due.pop_front();
                check_field("out_column", want.out_column, o_out_item.out_column);
                check_field("floor_row", want.floor_row, o_out_item.floor_row);
                check_field("ceiling_row", want.ceiling_row, o_out_item.ceiling_row);
                check_field("texel_x", want.texel_x, o_out_item.texel_x);
                check_field("texel_y", want.texel_y, o_out_item.texel_y);
            end
        end
    end

    // one long hold-off on the result side lets the input queue fill up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (!hold_done && n_popped >= 150) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PLAYER_X:       cfg_m.player_x = val;
            REG_PLAYER_Y:       cfg_m.player_y = val;
            REG_VIEW_DIR_X:     cfg_m.view_dir_x = val[15:0];
            REG_VIEW_DIR_Y:     cfg_m.view_dir_y = val[15:0];
            REG_CAMERA_PLANE_X: cfg_m.camera_plane_x = val[15:0];
            REG_CAMERA_PLANE_Y: cfg_m.camera_plane_y = val[15:0];
            REG_SCREEN_WIDTH:   cfg_m.screen_width = val[11:0];
            REG_SCREEN_HEIGHT:  cfg_m.screen_height = val[11:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input t_cfg c);
        write_reg(REG_PLAYER_X, c.player_x);
        write_reg(REG_PLAYER_Y, c.player_y);
        write_reg(REG_VIEW_DIR_X, 32'(c.view_dir_x));
        write_reg(REG_VIEW_DIR_Y, 32'(c.view_dir_y));
        write_reg(REG_CAMERA_PLANE_X, 32'(c.camera_plane_x));
        write_reg(REG_CAMERA_PLANE_Y, 32'(c.camera_plane_y));
        write_reg(REG_SCREEN_WIDTH, {20'd0, c.screen_width});
        write_reg(REG_SCREEN_HEIGHT, {20'd0, c.screen_height});
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_backlog.size() != 0 || push || texcoord_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_pixel(input logic [11:0] col, input logic [11:0] row,
                               input logic [31:0] px_dist);
        t_in_item px;
        px.column = col;
        px.row = row;
        px.row_distance = px_dist;
        pixel_backlog.push_back(px);
        n_queued++;
    endtask

    function automatic logic [31:0] pick_dist();
        case ($urandom_range(3))
            0:       return $urandom_range(32'h0010_0000);
            1:       return $urandom_range(32'h0400_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_row(input int len);
        logic [11:0] row;
        logic [31:0] row_dist;
        row = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(479));
        row_dist = pick_dist();
        queue_pixel(12'd0, row, row_dist);
        for (int c = 1; c <= len; c++)
            queue_pixel(12'(c), row, $urandom);  // distance ignored mid-row
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.player_x = $urandom;
        c.player_y = $urandom;
        if ($urandom_range(1)) begin
            c.view_dir_x = 16'($urandom);
            c.view_dir_y = 16'($urandom);
            c.camera_plane_x = 16'($urandom);
            c.camera_plane_y = 16'($urandom);
        end else begin
            c.view_dir_x = 16'($signed($urandom_range(32768)) - 16384);
            c.view_dir_y = 16'($signed($urandom_range(32768)) - 16384);
            c.camera_plane_x = 16'($signed($urandom_range(21626)) - 10813);
            c.camera_plane_y = 16'($signed($urandom_range(21626)) - 10813);
        end
        case ($urandom_range(3))
            0:       c.screen_width = 12'($urandom_range(1, 4095));
            default: c.screen_width = 12'($urandom_range(1, 64));
        endcase
        c.screen_height = 12'($urandom);
        return c;
    endfunction

    initial begin
        t_cfg c;
        int   goal;
        int   k;

        cfg_m = '0;
        cfg_m.screen_width = SCREEN_WIDTH_RST;
        cfg_m.screen_height = SCREEN_HEIGHT_RST;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings; mid-row pixel before any row start
        queue_pixel(12'd5, 12'd3, 32'd123);
        queue_pixel(12'd0, 12'd0, 32'd0);
        queue_pixel(12'd1, 12'd0, 32'd0);
        drain();

        // looking along -x, plane along y: negative world positions
        c = '0;
        c.player_x = 32'h0002_8000;
        c.player_y = 32'hFFFC_C000;
        c.view_dir_x = -16'sd16384;
        c.camera_plane_y = 16'sd10813;
        c.screen_width = 12'd640;
        c.screen_height = 12'd480;
        apply_cfg(c);
        queue_pixel(12'd0, 12'd240, 32'h0002_0000);
        for (int i = 1; i <= 4; i++)
            queue_pixel(12'(i), 12'd240, 32'h0002_0000);
        queue_pixel(12'd0, 12'd4095, 32'hFFFF_FFFF);  // row past screen height
        queue_pixel(12'd1, 12'd4095, 32'd0);
        queue_pixel(12'd2, 12'd4095, 32'd0);
        queue_pixel(12'd4095, 12'd0, 32'd0);
        drain();

        // extreme positions and directions, single-pixel screen
        c.player_x = 32'h7FFF_FFFF;
        c.player_y = 32'h8000_0000;
        c.view_dir_x = 16'sh7FFF;
        c.view_dir_y = 16'sh8000;
        c.camera_plane_x = 16'sh8000;
        c.camera_plane_y = 16'sh7FFF;
        c.screen_width = 12'd1;
        c.screen_height = 12'd1;
        apply_cfg(c);
        queue_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
        queue_pixel(12'd1, 12'd0, 32'hFFFF_FFFF);
        queue_pixel(12'd2, 12'd0, 32'hFFFF_FFFF);
        queue_pixel(12'd0, 12'd1, 32'd1);
        queue_pixel(12'd1, 12'd1, 32'd1);
        drain();

        // zero width falls back to one
        c.player_x = 32'hFFFF_0000;
        c.player_y = 32'h0000_4000;
        c.view_dir_x = 16'sh1234;
        c.view_dir_y = -16'sh2345;
        c.camera_plane_x = -16'sh0F00;
        c.camera_plane_y = 16'sh0ABC;
        c.screen_width = 12'd0;
        c.screen_height = 12'd4095;
        apply_cfg(c);
        queue_pixel(12'd0, 12'd4095, 32'h1234_5678);
        queue_pixel(12'd1, 12'd4095, 32'd0);
        queue_pixel(12'd2, 12'd4095, 32'd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            c = random_cfg();
            if (ph == 1)
                c.screen_width = 12'd4095;
            apply_cfg(c);
            // one phase runs with both sides always ready
            push_idle_pct = (ph == 3) ? 0 : 34;
            pop_idle_pct = (ph == 3) ? 0 : 34;
            goal = n_queued + 125;
            while (n_queued < goal) begin
                k = $urandom_range(99);
                if (k < 80) begin
                    queue_row(($urandom_range(7) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12));
                end else if (k < 90) begin
                    queue_pixel(12'($urandom), 12'($urandom), $urandom);
                end else begin
                    // broken row: start then scattered columns
                    queue_pixel(12'd0, 12'($urandom), pick_dist());
                    repeat ($urandom_range(1, 4))
                        queue_pixel(12'($urandom_range(1, 4095)), 12'($urandom), $urandom);
                end
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
